// ----- design/ntc_pkg.sv -----
// shared constants, codes and types for the thermistor temperature pipeline
package ntc_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int RES_W = 20;
  localparam int INV_W = 32;
  localparam int BETA_W = 15;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LOG_FRAC = 30;
  localparam int TEMP_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_NOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd3;

  localparam logic [RES_W-1:0] SERIES_RST = 20'd10000;
  localparam logic [RES_W-1:0] NOMINAL_RST = 20'd10000;
  localparam logic [INV_W-1:0] INV_NOM_RST = 32'd14405391;
  localparam logic [BETA_W-1:0] BETA_RST = 15'd3950;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int CENTI_ZERO_C = 27315;
  localparam int TEMP_MAX = 50000;
  localparam logic signed [TEMP_W-1:0] TEMP_RAIL = -17'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_SAT = 17'sd50000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RAIL = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic vld;
    logic rail;
    logic neg;
    logic nonpos;
  } ctl_t;

endpackage

// ----- design/ntc_log2.sv -----
// pipelined log2 unit, a normalizing stage then one squaring step per stage, unsigned q30 result
module ntc_log2 #(
  parameter int XW = 20
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [XW-1:0]                            x,
  output logic [$clog2(XW)+ntc_pkg::LOG_FRAC-1:0]  y
);

  localparam int FRAC = ntc_pkg::LOG_FRAC;
  localparam int EW = $clog2(XW);
  localparam int NST = FRAC + 1;

  logic [EW-1:0]   e_c;
  logic [FRAC:0]   m_c;
  logic [4:0]      sh_c;

  logic [FRAC:0]   m_q [NST];
  logic [EW-1:0]   e_q [NST];
  logic [FRAC-1:0] fr_q [NST];
  logic [FRAC:0]   m_n [NST];
  logic [FRAC-1:0] fr_n [NST];

  always_comb begin
    e_c = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        e_c = EW'(i);
      end
    end
    sh_c = 5'(FRAC) - 5'(e_c);
    m_c = (FRAC+1)'(x) << sh_c;
  end

  assign m_n[0] = m_c;
  assign fr_n[0] = '0;

  for (genvar j = 1; j < NST; j++) begin : g_sq
    logic [2*FRAC+1:0] sq;
    logic [FRAC+1:0]   t;
    assign sq = (2*FRAC+2)'(m_q[j-1]) * (2*FRAC+2)'(m_q[j-1]);
    assign t = sq[2*FRAC+1:FRAC];
    assign m_n[j] = t[FRAC+1] ? t[FRAC+1:1] : t[FRAC:0];
    assign fr_n[j] = fr_q[j-1] | (FRAC'(t[FRAC+1]) << (FRAC - j));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q[0] <= e_c;
      for (int k = 0; k < NST; k++) begin
        m_q[k] <= m_n[k];
        fr_q[k] <= fr_n[k];
      end
      for (int k = 1; k < NST; k++) begin
        e_q[k] <= e_q[k-1];
      end
    end
  end

  assign y = {e_q[NST-1], fr_q[NST-1]};

endmodule

// ----- design/ntc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module ntc_div #(
  parameter int NW = 40,
  parameter int DW = 39
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] rem_n [NW];
  logic [NW-1:0] num_n [NW];
  logic [DW-1:0] den_n [NW];
  logic [NW-1:0] quo_n [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [NW-1:0] num_p;
    logic [NW-1:0] quo_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    if (g == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den;
      assign num_p = num;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[g-1];
      assign den_p = den_q[g-1];
      assign num_p = num_q[g-1];
      assign quo_p = quo_q[g-1];
    end
    assign trial = {rem_p, num_p[NW-1]};
    assign ge = trial >= {1'b0, den_p};
    assign diff = trial - {1'b0, den_p};
    assign rem_n[g] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign num_n[g] = num_p << 1;
    assign den_n[g] = den_p;
    assign quo_n[g] = {quo_p[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_q[k] <= rem_n[k];
        num_q[k] <= num_n[k];
        den_q[k] <= den_n[k];
        quo_q[k] <= quo_n[k];
      end
    end
  end

  assign quo = quo_q[NW-1];

endmodule

// ----- design/ntc_thermistor_to_celsius.sv -----
// top level: thermistor sample to centi-celsius through the beta equation
// throughput: one item per cycle unless the output is stalled; the depth is set by the
// 31-stage log2 units and the 38-stage and 40-stage bit-per-stage dividers
// the whole pipeline advances together and holds while the output item is stalled
// reset clears all valid bits and loads the default register values
module ntc_thermistor_to_celsius #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ADC_BITS-1:0]                 adc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0]   temp_centi_celsius,
  output logic [1:0]                          status,
  input  logic                                cfg_write,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int RES_W = ntc_pkg::RES_W;
  localparam int FRAC = ntc_pkg::LOG_FRAC;
  localparam int LW_R = $clog2(RES_W) + FRAC;
  localparam int LW_A = $clog2(ADC_BITS) + FRAC;
  localparam int SUM_W = 36;
  localparam int NW1 = 38;
  localparam int NW2 = 40;
  localparam int DW2 = 39;
  localparam int K_MAG = FRAC + 1;
  localparam int K_LNA = K_MAG + 1;
  localparam int K_LNB = K_MAG + 2;
  localparam int K_Q1 = K_LNB + NW1;
  localparam int K_INV = K_Q1 + 1;
  localparam int K_NUM2 = K_INV + 1;
  localparam int K_Q2 = K_NUM2 + NW2;
  localparam int K_OUT = K_Q2 + 1;
  localparam int NSTG = K_OUT + 1;
  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

  logic [RES_W-1:0]             series;
  logic [RES_W-1:0]             nominal;
  logic [ntc_pkg::INV_W-1:0]    inv_nom;
  logic [ntc_pkg::BETA_W-1:0]   beta;

  logic                         en;
  logic                         rail;
  logic [RES_W-1:0]             series_eff;
  logic [RES_W-1:0]             nominal_eff;
  logic [ntc_pkg::BETA_W-1:0]   beta_eff;
  logic [ADC_BITS-1:0]          fms;

  logic [LW_R-1:0]              y_ser;
  logic [LW_R-1:0]              y_nom;
  logic [LW_A-1:0]              y_s;
  logic [LW_A-1:0]              y_fms;

  ntc_pkg::ctl_t                ctl_q [NSTG];
  ntc_pkg::ctl_t                ctl_d [NSTG];

  logic [SUM_W-1:0]             pos_c;
  logic [SUM_W-1:0]             neg_sum_c;
  logic                         neg_c;
  logic [SUM_W-1:0]             mag_c;
  logic [SUM_W-1:0]             mag;
  logic [51:0]                  ln_a;
  logic [47:0]                  ln_b;
  logic [48:0]                  low_sum;
  logic [NW1-1:0]               ln_c;
  logic [NW1-1:0]               num1;
  logic [NW1-1:0]               q1;
  logic [NW2-1:0]               inv_c;
  logic                         nonpos_c;
  logic [NW2-1:0]               inv_t;
  logic [NW2-1:0]               num2;
  logic [DW2-1:0]               den2;
  logic [NW2-1:0]               q2;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_c;
  logic [1:0]                   status_c;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_q;
  logic [1:0]                   status_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      series <= ntc_pkg::SERIES_RST;
      nominal <= ntc_pkg::NOMINAL_RST;
      inv_nom <= ntc_pkg::INV_NOM_RST;
      beta <= ntc_pkg::BETA_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ntc_pkg::REG_SERIES: series <= cfg_data[RES_W-1:0];
        ntc_pkg::REG_NOMINAL: nominal <= cfg_data[RES_W-1:0];
        ntc_pkg::REG_INV_NOM: inv_nom <= cfg_data[ntc_pkg::INV_W-1:0];
        ntc_pkg::REG_BETA: beta <= cfg_data[ntc_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  assign rail = (adc_sample == '0) || (adc_sample == FULL);
  assign series_eff = (series == '0) ? RES_W'(1) : series;
  assign nominal_eff = (nominal == '0) ? RES_W'(1) : nominal;
  assign beta_eff = (beta == '0) ? ntc_pkg::BETA_W'(1) : beta;
  assign fms = FULL - adc_sample;

  ntc_log2 #(.XW(RES_W)) u_log_ser (.clk(clk), .en(en), .x(series_eff), .y(y_ser));
  ntc_log2 #(.XW(RES_W)) u_log_nom (.clk(clk), .en(en), .x(nominal_eff), .y(y_nom));
  ntc_log2 #(.XW(ADC_BITS)) u_log_s (.clk(clk), .en(en), .x(adc_sample), .y(y_s));
  ntc_log2 #(.XW(ADC_BITS)) u_log_fms (.clk(clk), .en(en), .x(fms), .y(y_fms));

  // log of the resistance ratio, sign and magnitude
  always_comb begin
    pos_c = SUM_W'(y_ser) + SUM_W'(y_s);
    neg_sum_c = SUM_W'(y_fms) + SUM_W'(y_nom);
    neg_c = neg_sum_c > pos_c;
    mag_c = neg_c ? (neg_sum_c - pos_c) : (pos_c - neg_sum_c);
  end

  // natural log as two partial products, then rounding offset for beta
  always_comb begin
    low_sum = 49'({ln_a[13:0], 16'b0}) + 49'(ln_b);
    ln_c = NW1'(ln_a[51:14]) + NW1'(low_sum[48:30]);
  end

  ntc_div #(.NW(NW1), .DW(ntc_pkg::BETA_W)) u_div_beta (
    .clk(clk), .en(en), .num(num1), .den(beta_eff), .quo(q1)
  );

  always_comb begin
    if (ctl_q[K_Q1].neg) begin
      inv_c = NW2'(inv_nom) - NW2'(q1);
    end else begin
      inv_c = NW2'(inv_nom) + NW2'(q1);
    end
    nonpos_c = inv_c[NW2-1] || (inv_c == '0);
  end

  ntc_div #(.NW(NW2), .DW(DW2)) u_div_temp (
    .clk(clk), .en(en), .num(num2), .den(den2), .quo(q2)
  );

  // rail code, offset to celsius and saturation
  always_comb begin
    if (ctl_q[K_Q2].rail) begin
      temp_c = ntc_pkg::TEMP_RAIL;
      status_c = ntc_pkg::ST_RAIL;
    end else if (ctl_q[K_Q2].nonpos ||
                 (q2 > NW2'(ntc_pkg::TEMP_MAX + ntc_pkg::CENTI_ZERO_C))) begin
      temp_c = ntc_pkg::TEMP_SAT;
      status_c = ntc_pkg::ST_SAT;
    end else begin
      temp_c = $signed(q2[ntc_pkg::TEMP_W-1:0] - ntc_pkg::TEMP_W'(ntc_pkg::CENTI_ZERO_C));
      status_c = ntc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_c;
      ln_a <= 52'(mag[SUM_W-1:16]) * 52'(ntc_pkg::LN2_Q32);
      ln_b <= 48'(mag[15:0]) * 48'(ntc_pkg::LN2_Q32);
      num1 <= ln_c + NW1'(beta_eff[ntc_pkg::BETA_W-1:1]);
      inv_t <= inv_c;
      num2 <= (NW2'(100) << 32) + NW2'(inv_t[DW2-1:1]);
      den2 <= inv_t[DW2-1:0];
      temp_q <= temp_c;
      status_q <= status_c;
    end
  end

  // item flags travel alongside the data
  always_comb begin
    ctl_d[0] = '{vld: in_valid, rail: rail, neg: 1'b0, nonpos: 1'b0};
    for (int k = 1; k < NSTG; k++) begin
      ctl_d[k] = ctl_q[k-1];
    end
    ctl_d[K_MAG].neg = neg_c;
    ctl_d[K_INV].nonpos = nonpos_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        ctl_q[k].vld <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        ctl_q[k].vld <= ctl_d[k].vld;
      end
    end
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        ctl_q[k].rail <= ctl_d[k].rail;
        ctl_q[k].neg <= ctl_d[k].neg;
        ctl_q[k].nonpos <= ctl_d[k].nonpos;
      end
    end
  end

  assign out_valid = ctl_q[K_OUT].vld;
  assign temp_centi_celsius = temp_q;
  assign status = status_q;

  a_rail_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntc_pkg::ST_RAIL) |-> temp_centi_celsius == ntc_pkg::TEMP_RAIL)
    else $error("rail item without rail temperature");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntc_pkg::ST_SAT) |-> temp_centi_celsius == ntc_pkg::TEMP_SAT)
    else $error("saturated item without limit temperature");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntc_pkg::ST_OK) |->
      (temp_centi_celsius >= ntc_pkg::TEMP_RAIL) && (temp_centi_celsius <= ntc_pkg::TEMP_SAT))
    else $error("valid item out of range");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ntc_pkg::ST_OK) || (status == ntc_pkg::ST_RAIL) ||
                  (status == ntc_pkg::ST_SAT))
    else $error("undefined status code");

endmodule

// ----- bench/ntc_temp_checker.sv -----
// checker for the thermistor pipeline: predicts each item's temperature and compares results
module ntc_temp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [9:0]                          adc_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [ntc_pkg::TEMP_W-1:0]   temp_centi_celsius,
  input  logic [1:0]                          status,
  input  logic                                cfg_write,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntc_pkg::CFG_W-1:0]           cfg_data,
  output int                                  fails,
  output int                                  pending,
  output int                                  n_checked,
  output int                                  n_rail,
  output int                                  n_sat
);

  localparam longint unsigned FULL = 64'd1023;

  typedef struct packed {
    logic signed [ntc_pkg::TEMP_W-1:0] temp;
    logic [1:0]                        st;
  } temp_item_t;

  temp_item_t expected_temps[$];

  logic [ntc_pkg::RES_W-1:0]  series_r;
  logic [ntc_pkg::RES_W-1:0]  nominal_r;
  logic [ntc_pkg::INV_W-1:0]  inv_nom;
  logic [ntc_pkg::BETA_W-1:0] beta_r;

  function automatic longint unsigned log2_fix(longint unsigned x);
    int unsigned e;
    longint unsigned m, r;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    r = longint'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << i);
      end
    end
    return r;
  endfunction

  function automatic longint unsigned ln_of_log2(longint unsigned q);
    longint unsigned hi, lo, a, b;
    hi = q >> 16;
    lo = q & 64'hFFFF;
    a = hi * longint'(ntc_pkg::LN2_Q32);
    b = lo * longint'(ntc_pkg::LN2_Q32);
    return (a >> 14) + ((((a & 64'h3FFF) << 16) + b) >> 30);
  endfunction

  function automatic temp_item_t beta_temp_predict(logic [9:0] smp);
    temp_item_t o;
    longint unsigned s, ser, nom, beta, pos, neg, mag, term, ck;
    longint inv_t, c;
    logic negative;
    s = smp;
    ser = (series_r == 0) ? 1 : series_r;
    nom = (nominal_r == 0) ? 1 : nominal_r;
    beta = (beta_r == 0) ? 1 : beta_r;
    if (s == 0 || s >= FULL) begin
      o.temp = ntc_pkg::TEMP_RAIL;
      o.st = ntc_pkg::ST_RAIL;
      return o;
    end
    pos = log2_fix(ser) + log2_fix(s);
    neg = log2_fix(FULL - s) + log2_fix(nom);
    negative = neg > pos;
    mag = ln_of_log2(negative ? neg - pos : pos - neg);
    term = (mag + beta / 2) / beta;
    inv_t = longint'(inv_nom) + (negative ? -longint'(term) : longint'(term));
    if (inv_t <= 0) begin
      o.temp = ntc_pkg::TEMP_SAT;
      o.st = ntc_pkg::ST_SAT;
      return o;
    end
    ck = ((64'd100 << 32) + longint'(inv_t) / 2) / longint'(inv_t);
    c = longint'(ck) - ntc_pkg::CENTI_ZERO_C;
    if (c > ntc_pkg::TEMP_MAX) begin
      o.temp = ntc_pkg::TEMP_SAT;
      o.st = ntc_pkg::ST_SAT;
      return o;
    end
    o.temp = c[ntc_pkg::TEMP_W-1:0];
    o.st = ntc_pkg::ST_OK;
    return o;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  initial begin
    fails = 0;
    n_checked = 0;
    n_rail = 0;
    n_sat = 0;
  end

  assign pending = expected_temps.size();

  always @(posedge clk) begin
    temp_item_t exp_t;
    if (rst) begin
      series_r <= ntc_pkg::SERIES_RST;
      nominal_r <= ntc_pkg::NOMINAL_RST;
      inv_nom <= ntc_pkg::INV_NOM_RST;
      beta_r <= ntc_pkg::BETA_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ntc_pkg::REG_SERIES:  series_r <= cfg_data[ntc_pkg::RES_W-1:0];
          ntc_pkg::REG_NOMINAL: nominal_r <= cfg_data[ntc_pkg::RES_W-1:0];
          ntc_pkg::REG_INV_NOM: inv_nom <= cfg_data[ntc_pkg::INV_W-1:0];
          ntc_pkg::REG_BETA:    beta_r <= cfg_data[ntc_pkg::BETA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_temps.push_back(beta_temp_predict(adc_sample));
      if (out_valid && !out_stall) begin
        if (expected_temps.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          exp_t = expected_temps.pop_front();
          n_checked++;
          if (exp_t.st == ntc_pkg::ST_RAIL) n_rail++;
          if (exp_t.st == ntc_pkg::ST_SAT) n_sat++;
          if (temp_centi_celsius !== exp_t.temp)
            report($sformatf("temp %0d, expected %0d", temp_centi_celsius, exp_t.temp));
          if (status !== exp_t.st)
            report($sformatf("status %0d, expected %0d", status, exp_t.st));
        end
      end
    end
  end
endmodule

// ----- bench/tb_ntc_thermistor_to_celsius.sv -----
// testbench top for the thermistor pipeline: stimulus, register phases and verdict
module tb_ntc_thermistor_to_celsius;

  localparam int DRAIN = 130;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [9:0] adc_sample = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_centi_celsius;
  logic [1:0] status;
  logic cfg_write = 0;
  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ntc_pkg::CFG_W-1:0] cfg_data = '0;

  int fails, pending, n_checked, n_rail, n_sat;
  int burst_left = 0;
  int hold_req = 0;
  int n_phases = 0;

  always #6 clk = ~clk;

  ntc_thermistor_to_celsius uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .out_valid(out_valid), .out_stall(out_stall),
    .temp_centi_celsius(temp_centi_celsius), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ntc_temp_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .out_valid(out_valid), .out_stall(out_stall),
    .temp_centi_celsius(temp_centi_celsius), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .n_checked(n_checked),
    .n_rail(n_rail), .n_sat(n_sat)
  );

  // receiver: random stalls at a rate drawn from four levels, plus one long hold on request
  initial begin
    int hold_cnt, pct, cyc;
    hold_cnt = 0;
    pct = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_req == 1) begin
        hold_req = 2;
        hold_cnt = 400;
      end
      if (cyc % 200 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 90;
        endcase
      end
      cyc++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  task automatic send_item(logic [9:0] smp);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid = 1'b1;
    adc_sample = smp;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [ntc_pkg::CFG_IDX_W-1:0] idx, logic [ntc_pkg::CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_regs(logic [ntc_pkg::CFG_W-1:0] ser, logic [ntc_pkg::CFG_W-1:0] nom,
                          logic [ntc_pkg::CFG_W-1:0] inv, logic [ntc_pkg::CFG_W-1:0] beta);
    drain();
    write_reg(ntc_pkg::REG_SERIES, ser);
    write_reg(ntc_pkg::REG_NOMINAL, nom);
    write_reg(ntc_pkg::REG_INV_NOM, inv);
    write_reg(ntc_pkg::REG_BETA, beta);
    n_phases++;
  endtask

  function automatic logic [9:0] rand_sample();
    case ($urandom_range(0, 19))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'($urandom_range(1, 8));
      3: return 10'($urandom_range(1015, 1022));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) send_item(rand_sample());
  endtask

  initial begin
    logic [9:0] directed[] = '{10'd0, 10'd1023, 10'd1, 10'd2, 10'd1022, 10'd1021, 10'd511,
                               10'd512, 10'd341, 10'd682, 10'h155, 10'h2AA, 10'd100,
                               10'd900, 10'd256, 10'd768};
    repeat (3) @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) send_item(directed[i]);
    hold_req = 1;
    random_items(300);
    set_regs(1, 32'hFFFFF, 32'hFFFFFFFF, 20000);
    foreach (directed[i]) send_item(directed[i]);
    random_items(150);
    set_regs(32'hFFFFF, 1, 1, 1);
    foreach (directed[i]) send_item(directed[i]);
    random_items(150);
    set_regs(0, 0, 14405391, 0);
    random_items(150);
    set_regs(32'hFFFFF, 32'hFFFFF, 32'h80000000, 15'h7FFF);
    random_items(150);
    set_regs(10000, 10000, 14405391, 3950);
    random_items(200);
    repeat (6) begin
      set_regs($urandom_range(1, 32'hFFFFF), $urandom_range(1, 32'hFFFFF),
               $urandom, $urandom_range(0, 32767));
      random_items(150);
    end
    drain();
    $display("checked %0d results over %0d register settings", n_checked, n_phases + 1);
    $display("%0d rail samples and %0d saturated results among them", n_rail, n_sat);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("status: fail");
    $finish;
  end
endmodule
